// ===== sv/bpa_pkg.sv =====
`timescale 1ns / 1ps
// Package for the binary patch apply unit: phase encoding, operation and
// status codes, record layout and the 8-byte patch magic. No dependencies.
package bpa_pkg;

  typedef enum logic [6:0] {
    PH_MAGIC  = 7'b0000001,
    PH_HEADER = 7'b0000010,
    PH_RECORD = 7'b0000100,
    PH_COPY   = 7'b0001000,
    PH_DROP   = 7'b0010000,
    PH_LIT    = 7'b0100000,
    PH_HALT   = 7'b1000000
  } phase_t;

  typedef enum logic [1:0] {
    OP_PATCH_BYTE = 2'd0,
    OP_OLD_BYTE   = 2'd1,
    OP_PATCH_END  = 2'd2,
    OP_OLD_END    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_RUN   = 3'd0,
    ST_DONE  = 3'd1,
    ST_MAGIC = 3'd2,
    ST_TRUNC = 3'd3,
    ST_NEG   = 3'd4,
    ST_TURN  = 3'd5
  } status_t;

  localparam int unsigned REC_LEN    = 24;
  localparam int unsigned MAGIC_LEN  = 8;
  localparam int unsigned HEADER_LEN = 8;
  localparam int unsigned MAG_BITS   = 63;

  typedef logic [7:0] byte_t;
  typedef logic [MAG_BITS-1:0] mag_t;

  // Magic text, eight ASCII bytes ending in a space
  function automatic byte_t magic_byte(input logic [2:0] idx);
    byte_t b;
    case (idx)
      3'd0:    b = 8'h4E;
      3'd1:    b = 8'h49;
      3'd2:    b = 8'h4C;
      3'd3:    b = 8'h45;
      3'd4:    b = 8'h31;
      3'd5:    b = 8'h2E;
      3'd6:    b = 8'h30;
      3'd7:    b = 8'h20;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== sv/binary_patch_apply_unit.sv =====
`timescale 1ns / 1ps
// Binary patch apply unit: top level, byte-serial patch decoder.
// Depends on bpa_pkg.
//
// Takes one patch or old-file byte per clock while in_stall is low and returns
// one result word per byte in the cycle after acceptance. The per-byte work
// (magic compare, record capture, count decode and the 63-bit count decrement)
// sits between the input handshake and a single result register, so the unit
// sustains one word per cycle; in_stall rises only while a result waits with
// res_stall high. want_old on each result tells the feeder which stream
// supplies the next data word. Once a status other than running is reported
// the unit ignores further input and repeats that status.
module binary_patch_apply_unit import bpa_pkg::*; #(
  parameter int unsigned COUNT_BITS   = 63,
  parameter int unsigned DIGEST_BYTES = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] operation,
  input  logic [7:0] data_byte,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic       want_old,
  output logic [2:0] status
);

  localparam logic [COUNT_BITS-1:0] HEADER_SKIP = COUNT_BITS'(HEADER_LEN + 2 * DIGEST_BYTES);
  localparam logic [4:0] REC_LAST   = 5'(REC_LEN - 1);
  localparam logic [4:0] MAGIC_LAST = 5'(MAGIC_LEN - 1);

  typedef logic [COUNT_BITS-1:0] cnt_t;

  phase_t     phase, phase_next;
  logic [4:0] byte_index, byte_index_next;
  cnt_t       remaining_count, remaining_count_next;
  status_t    error_latched, error_latched_next;
  byte_t      record_bytes [REC_LEN];

  byte_t   rec_view [REC_LEN];
  mag_t    mag [3];
  cnt_t    cnt [3];
  logic    cnt_zero [3];
  logic    neg_any;
  logic    in_acc;
  op_t     op;
  byte_t   ob;
  logic    ov;

  assign in_stall = res_valid & res_stall;
  assign in_acc   = in_valid & ~in_stall;
  assign op       = op_t'(operation);

  // Record as seen this cycle: the last byte may be arriving now
  always_comb begin
    for (int i = 0; i < REC_LEN; i++) begin
      rec_view[i] = record_bytes[i];
    end
    rec_view[REC_LEN-1] = data_byte;
    if (byte_index != REC_LAST || phase != PH_RECORD) begin
      rec_view[REC_LEN-1] = record_bytes[REC_LEN-1];
    end
  end

  // Decode the three sign-magnitude counts, saturating to COUNT_BITS
  always_comb begin
    neg_any = 1'b0;
    for (int c = 0; c < 3; c++) begin
      mag[c] = {rec_view[c*8+7][6:0], rec_view[c*8+6], rec_view[c*8+5], rec_view[c*8+4],
                rec_view[c*8+3], rec_view[c*8+2], rec_view[c*8+1], rec_view[c*8]};
      cnt[c] = ((mag[c] >> COUNT_BITS) != '0) ? '1 : mag[c][COUNT_BITS-1:0];
      cnt_zero[c] = (mag[c] == '0);
      neg_any = neg_any | (rec_view[c*8+7][7] & ~cnt_zero[c]);
    end
  end

  always_comb begin
    phase_next           = phase;
    byte_index_next      = byte_index;
    remaining_count_next = remaining_count;
    error_latched_next   = error_latched;
    ob = '0;
    ov = 1'b0;
    if (in_acc) begin
      case (phase)
        PH_COPY, PH_DROP: begin
          if (op == OP_PATCH_BYTE || op == OP_PATCH_END) begin
            phase_next         = PH_HALT;
            error_latched_next = ST_TURN;
          end else if (op == OP_OLD_END) begin
            // abandon copy and drop, go to the literal part, or to the next record if it is empty
            if (cnt_zero[2]) begin
              phase_next      = PH_RECORD;
              byte_index_next = '0;
            end else begin
              phase_next           = PH_LIT;
              remaining_count_next = cnt[2];
            end
          end else begin
            if (phase == PH_COPY) begin
              ob = data_byte;
              ov = 1'b1;
            end
            remaining_count_next = remaining_count - cnt_t'(1);
            if (remaining_count == cnt_t'(1)) begin
              if (phase == PH_COPY && !cnt_zero[1]) begin
                phase_next           = PH_DROP;
                remaining_count_next = cnt[1];
              end else if (!cnt_zero[2]) begin
                phase_next           = PH_LIT;
                remaining_count_next = cnt[2];
              end else begin
                phase_next      = PH_RECORD;
                byte_index_next = '0;
              end
            end
          end
        end
        PH_HALT: begin
        end
        default: begin
          if (op == OP_OLD_BYTE) begin
            phase_next         = PH_HALT;
            error_latched_next = ST_TURN;
          end else if (op == OP_PATCH_END) begin
            phase_next = PH_HALT;
            if (phase == PH_MAGIC) begin
              error_latched_next = ST_MAGIC;
            end else if (phase == PH_RECORD && byte_index == '0) begin
              error_latched_next = ST_DONE;
            end else begin
              error_latched_next = ST_TRUNC;
            end
          end else if (op == OP_PATCH_BYTE) begin
            case (phase)
              PH_MAGIC: begin
                if (data_byte != magic_byte(byte_index[2:0])) begin
                  phase_next         = PH_HALT;
                  error_latched_next = ST_MAGIC;
                end else if (byte_index == MAGIC_LAST) begin
                  phase_next           = PH_HEADER;
                  byte_index_next      = '0;
                  remaining_count_next = HEADER_SKIP;
                end else begin
                  byte_index_next = byte_index + 5'd1;
                end
              end
              PH_HEADER: begin
                remaining_count_next = remaining_count - cnt_t'(1);
                if (remaining_count == cnt_t'(1)) begin
                  phase_next      = PH_RECORD;
                  byte_index_next = '0;
                end
              end
              PH_RECORD: begin
                byte_index_next = byte_index + 5'd1;
                if (byte_index == REC_LAST) begin
                  byte_index_next = '0;
                  if (neg_any) begin
                    phase_next         = PH_HALT;
                    error_latched_next = ST_NEG;
                  end else if (!cnt_zero[0]) begin
                    phase_next           = PH_COPY;
                    remaining_count_next = cnt[0];
                  end else if (!cnt_zero[1]) begin
                    phase_next           = PH_DROP;
                    remaining_count_next = cnt[1];
                  end else if (!cnt_zero[2]) begin
                    phase_next           = PH_LIT;
                    remaining_count_next = cnt[2];
                  end
                end
              end
              PH_LIT: begin
                ob = data_byte;
                ov = 1'b1;
                remaining_count_next = remaining_count - cnt_t'(1);
                if (remaining_count == cnt_t'(1)) begin
                  phase_next      = PH_RECORD;
                  byte_index_next = '0;
                end
              end
              default: begin
              end
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_MAGIC;
      byte_index      <= '0;
      remaining_count <= '0;
      error_latched   <= ST_RUN;
      res_valid       <= 1'b0;
    end else begin
      phase           <= phase_next;
      byte_index      <= byte_index_next;
      remaining_count <= remaining_count_next;
      error_latched   <= error_latched_next;
      res_valid       <= in_acc | (res_valid & res_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && phase == PH_RECORD && op == OP_PATCH_BYTE) begin
      record_bytes[byte_index] <= data_byte;
    end
    if (in_acc) begin
      out_byte  <= ob;
      out_valid <= ov;
      want_old  <= (phase_next == PH_COPY) || (phase_next == PH_DROP);
      status    <= (phase_next == PH_HALT) ? error_latched_next : ST_RUN;
    end
  end

endmodule

// ===== sv/bpa_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the binary patch apply unit, bound to the top level.
// Depends on bpa_pkg.
module bpa_checker import bpa_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       res_valid,
  input logic       res_stall,
  input logic [7:0] out_byte,
  input logic       out_valid,
  input logic       want_old,
  input logic [2:0] status
);

  logic       res_acc;
  logic [2:0] last_status;

  assign res_acc = res_valid & ~res_stall;

  // remember the status of the last word taken
  always_ff @(posedge clk) begin
    if (rst) begin
      last_status <= ST_RUN;
    end else if (res_acc) begin
      last_status <= status;
    end
  end

  a_final_status_sticks: assert property (@(posedge clk) disable iff (rst)
    (res_acc && last_status != ST_RUN) |-> (status == last_status))
    else $error("final status changed after halt");

  a_halt_quiet: assert property (@(posedge clk) disable iff (rst)
    (res_valid && status != ST_RUN) |-> (!out_valid && !want_old))
    else $error("halted word carries data or old-byte request");

  a_empty_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !out_valid) |-> (out_byte == 8'd0))
    else $error("out_byte nonzero without out_valid");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (res_valid && res_stall))
    else $error("input stalled while result side free");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(status) && $stable(out_byte)))
    else $error("stalled result word changed");

endmodule

bind binary_patch_apply_unit bpa_checker u_bpa_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .out_byte  (out_byte),
  .out_valid (out_valid),
  .want_old  (want_old),
  .status    (status)
);
